/* design/pfra_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator package
// Types, codes and constants shared by the allocator core and its testbench.
// ----------------------------------------------------------------------------
package pfra_pkg;

   localparam int ADDR_W      = 24;
   localparam int CSR_W       = 25;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W     = 8;
   localparam int BITMAP_WORD = 64;
   localparam int BIT_W       = 6;

   localparam logic [CSR_W-1:0] HOLE_START = 25'h00A0000;
   localparam logic [CSR_W-1:0] HOLE_END   = 25'h0100000;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_REF   = 2'd2,
      MODE_INIT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_USABLE_START = 2'd0,
      CSR_USABLE_END   = 2'd1,
      CSR_KERNEL_START = 2'd2,
      CSR_KERNEL_END   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_UPDATE,
      S_INIT,
      S_RESP
   } state_type;

   typedef struct packed {
      mode_type          mode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      status_type        status;
   } rsp_type;

endpackage
`default_nettype wire

/* design/page_frame_refcount_allocator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator with reference counts
// Keeps a free bitmap and a signed reference count for every page and serves
// allocate, free, reference and table initialize requests.
// ----------------------------------------------------------------------------
// The free bitmap lives in a RAM of 64-bit words and the counts in a RAM of
// one byte per page. Free and reference pass through a RAM read, an update
// and write-back, and a step into the result register. Allocate scans the
// bitmap one word per cycle starting at a low-water word below which no page
// is free. When the low-water word already shows that no page is free, and
// for a free or reference outside the table, the request goes to the result
// register with no RAM access. Initialize walks every page, one per cycle.
// After reset a clearing pass over every page runs before the first request
// is taken. One request is in work at a time; a new one is taken while an
// earlier result waits.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator_core #(
   parameter int NUM_PAGES  = 4096,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [pfra_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pfra_pkg::CSR_W-1:0]          csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pfra_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pfra_pkg::rsp_type                        rsp_data
);

   import pfra_pkg::*;

   localparam int PW        = $clog2(NUM_PAGES);
   localparam int SB        = $clog2(PAGE_BYTES);
   localparam int NUM_WORDS = (NUM_PAGES + BITMAP_WORD - 1) / BITMAP_WORD;
   localparam int WW        = PW - BIT_W;
   localparam int HW        = $clog2(NUM_WORDS + 1);
   localparam int AW        = (PW + SB > CSR_W) ? PW + SB : CSR_W;
   localparam int HOLE_LO   = (int'(HOLE_START) / PAGE_BYTES) * PAGE_BYTES;

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [PW-1:0]            page_ff, page_in;
   logic [WW-1:0]            word_idx_ff, word_idx_in;
   logic [HW-1:0]            hint_ff, hint_in;
   logic [BITMAP_WORD-1:0]   acc_ff, acc_in;
   rsp_type                  pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [CSR_W-1:0]         us_ff, us_in;
   logic [CSR_W-1:0]         ue_ff, ue_in;
   logic [CSR_W-1:0]         ks_ff, ks_in;
   logic [CSR_W-1:0]         ke_ff, ke_in;

   logic                     cnt_wr_en, cnt_rd_en;
   logic [PW-1:0]            cnt_wr_addr, cnt_rd_addr;
   logic [COUNT_W-1:0]       cnt_wr_data, cnt_rd_data;
   logic                     bm_wr_en, bm_rd_en;
   logic [WW-1:0]            bm_wr_addr, bm_rd_addr;
   logic [BITMAP_WORD-1:0]   bm_wr_data, bm_rd_data;

   logic                     req_fire;
   logic [ADDR_W-1:0]        req_page_full;
   logic                     req_out_of_range;
   logic [PW-1:0]            req_page;

   logic signed [COUNT_W-1:0] cnt_cur, cnt_dec, cnt_inc;
   logic [BITMAP_WORD-1:0]   page_mask;
   logic                     cur_free;
   logic [BIT_W-1:0]         low_bit;
   logic [PW-1:0]            found_page;

   logic [AW-1:0]            sweep_addr;
   logic                     sweep_usable, sweep_kernel, sweep_hole;
   logic                     sweep_free, sweep_reserved;
   logic [BITMAP_WORD-1:0]   sweep_word;
   logic                     sweep_last, sweep_word_end;

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [BITMAP_WORD-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = BITMAP_WORD - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

   pfra_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(NUM_PAGES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   pfra_ram #(
      .WIDTH(BITMAP_WORD),
      .DEPTH(NUM_WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign req_fire         = req_valid && !req_stall;
   assign req_page_full    = req_data.address >> SB;
   assign req_out_of_range = (32'(req_page_full) >= 32'(NUM_PAGES));
   assign req_page         = PW'(req_page_full);

   assign cnt_cur    = $signed(cnt_rd_data);
   assign cnt_dec    = cnt_cur - 8'sd1;
   assign cnt_inc    = (cnt_cur < COUNT_MAX) ? cnt_cur + 8'sd1 : cnt_cur;
   assign page_mask  = BITMAP_WORD'(1) << page_ff[BIT_W-1:0];
   assign cur_free   = bm_rd_data[page_ff[BIT_W-1:0]];
   assign low_bit    = lowest_bit(bm_rd_data);
   assign found_page = {word_idx_ff, low_bit};

   assign sweep_addr     = AW'(page_ff) << SB;
   assign sweep_usable   = (sweep_addr >= AW'(us_ff)) && (sweep_addr < AW'(ue_ff));
   assign sweep_kernel   = (sweep_addr >= (AW'(ks_ff >> SB) << SB)) &&
                           (sweep_addr < AW'(ke_ff));
   assign sweep_hole     = (sweep_addr >= AW'(HOLE_LO)) && (sweep_addr < AW'(HOLE_END));
   assign sweep_reserved = (state_ff == S_INIT) && (sweep_kernel || sweep_hole);
   assign sweep_free     = (state_ff == S_INIT) && sweep_usable && !sweep_kernel &&
                           !sweep_hole;
   assign sweep_word     = acc_ff | (BITMAP_WORD'(sweep_free) << page_ff[BIT_W-1:0]);
   assign sweep_last     = (page_ff == PW'(NUM_PAGES - 1));
   assign sweep_word_end = (page_ff[BIT_W-1:0] == '1) || sweep_last;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      page_in      = page_ff;
      word_idx_in  = word_idx_ff;
      hint_in      = hint_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      us_in        = us_ff;
      ue_in        = ue_ff;
      ks_in        = ks_ff;
      ke_in        = ke_ff;

      cnt_wr_en   = 1'b0;
      cnt_wr_addr = page_ff;
      cnt_wr_data = '0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = req_page;
      bm_wr_en    = 1'b0;
      bm_wr_addr  = page_ff[PW-1:BIT_W];
      bm_wr_data  = bm_rd_data;
      bm_rd_en    = 1'b0;
      bm_rd_addr  = req_page[PW-1:BIT_W];

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_USABLE_START: us_in = csr_write_data;
            CSR_USABLE_END:   ue_in = csr_write_data;
            CSR_KERNEL_START: ks_in = csr_write_data;
            CSR_KERNEL_END:   ke_in = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         S_CLEAR, S_INIT: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = sweep_reserved ? '1 : '0;
            acc_in      = sweep_word;
            if (sweep_word_end) begin
               bm_wr_en   = 1'b1;
               bm_wr_data = sweep_word;
               acc_in     = '0;
            end
            if (sweep_last) begin
               if (state_ff == S_INIT) begin
                  hint_in  = '0;
                  pend_in  = '{page_address: '0, status: STATUS_OK};
                  state_in = S_RESP;
               end else begin
                  hint_in  = HW'(NUM_WORDS);
                  state_in = S_IDLE;
               end
            end else begin
               page_in = page_ff + PW'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in = req_data.mode;
               page_in = req_page;
               unique case (req_data.mode) inside
                  MODE_ALLOC: begin
                     if (hint_ff >= HW'(NUM_WORDS)) begin
                        pend_in  = '{page_address: '0, status: STATUS_NO_FREE};
                        state_in = S_RESP;
                     end else begin
                        bm_rd_en    = 1'b1;
                        bm_rd_addr  = hint_ff[WW-1:0];
                        word_idx_in = hint_ff[WW-1:0];
                        state_in    = S_ALLOC;
                     end
                  end
                  MODE_FREE, MODE_REF: begin
                     if (req_out_of_range) begin
                        pend_in  = '{page_address: '0, status: STATUS_RANGE};
                        state_in = S_RESP;
                     end else begin
                        cnt_rd_en = 1'b1;
                        bm_rd_en  = 1'b1;
                        state_in  = S_UPDATE;
                     end
                  end
                  MODE_INIT: begin
                     page_in  = '0;
                     acc_in   = '0;
                     state_in = S_INIT;
                  end
                  default: ;
               endcase
            end
         end
         S_ALLOC: begin
            if (bm_rd_data != '0) begin
               bm_wr_en    = 1'b1;
               bm_wr_addr  = word_idx_ff;
               bm_wr_data  = bm_rd_data & ~(BITMAP_WORD'(1) << low_bit);
               cnt_wr_en   = 1'b1;
               cnt_wr_addr = found_page;
               cnt_wr_data = COUNT_W'(1);
               hint_in     = HW'(word_idx_ff);
               pend_in     = '{page_address: ADDR_W'(AW'(found_page) << SB),
                               status: STATUS_OK};
               state_in    = S_RESP;
            end else if (word_idx_ff == WW'(NUM_WORDS - 1)) begin
               hint_in  = HW'(NUM_WORDS);
               pend_in  = '{page_address: '0, status: STATUS_NO_FREE};
               state_in = S_RESP;
            end else begin
               bm_rd_en    = 1'b1;
               bm_rd_addr  = word_idx_ff + WW'(1);
               word_idx_in = word_idx_ff + WW'(1);
            end
         end
         S_UPDATE: begin
            pend_in  = '{page_address: '0, status: STATUS_OK};
            state_in = S_RESP;
            case (mode_ff)
               MODE_FREE: begin
                  if (!cur_free && (cnt_cur > 8'sd0)) begin
                     cnt_wr_en   = 1'b1;
                     cnt_wr_data = cnt_dec;
                     if (cnt_dec == 8'sd0) begin
                        bm_wr_en   = 1'b1;
                        bm_wr_data = bm_rd_data | page_mask;
                        if (HW'(page_ff[PW-1:BIT_W]) < hint_ff) begin
                           hint_in = HW'(page_ff[PW-1:BIT_W]);
                        end
                     end
                  end
               end
               default: begin
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = cnt_inc;
                  bm_wr_en    = 1'b1;
                  bm_wr_data  = bm_rd_data & ~page_mask;
               end
            endcase
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         page_ff      <= '0;
         acc_ff       <= '0;
         hint_ff      <= HW'(NUM_WORDS);
         rsp_valid_ff <= 1'b0;
         us_ff        <= 25'h0100000;
         ue_ff        <= 25'h1000000;
         ks_ff        <= 25'h0100000;
         ke_ff        <= 25'h0200000;
      end else begin
         state_ff     <= state_in;
         page_ff      <= page_in;
         acc_ff       <= acc_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         us_ff        <= us_in;
         ue_ff        <= ue_in;
         ks_ff        <= ks_in;
         ke_ff        <= ke_in;
      end
      mode_ff     <= mode_in;
      word_idx_ff <= word_idx_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR)
      else $error("clearing pass does not start after reset");

   a_hint_range: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= HW'(NUM_WORDS))
      else $error("low-water word beyond the bitmap");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP) |-> !cnt_wr_en && !bm_wr_en)
      else $error("table written outside a request");

   a_error_zero_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.page_address == '0)
      else $error("failed transfer carries a page address");
`endif

endmodule
`default_nettype wire

/* design/pfra_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module pfra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* test/tb_page_frame_refcount_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator core testbench
// A driver feeds allocate, free, reference and initialize requests from a
// backlog, and a mirror of the page table predicts the reply of each accepted
// transfer. A monitor compares every reply, field by field, with the oldest
// prediction. Region registers change only while the core is idle. Both sides
// idle at random, and once the receiver holds off long enough to back the
// core up.
// ----------------------------------------------------------------------------
module tb_page_frame_refcount_allocator_core;
   import pfra_pkg::*;

   localparam int NUM_FRAMES = 4096;
   localparam int FRAME_BYTES = 4096;
   localparam longint LIMIT_CYCLES = 1_500_000;
   localparam longint TOP_BYTE = 25'h1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type request_backlog[$];
   rsp_type predicted_replies[$];
   rsp_type oldest_reply;

   logic [CSR_W-1:0] region_reg[4];
   bit frame_free[NUM_FRAMES];
   logic signed [COUNT_W-1:0] frame_count[NUM_FRAMES];

   int mismatch_count = 0;
   int send_idle_pct = 34;
   int recv_idle_pct = 74;
   int send_calm = 0;
   int recv_calm = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   page_frame_refcount_allocator_core #(
      .NUM_PAGES(NUM_FRAMES),
      .PAGE_BYTES(FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void reserve_frames(longint lo_byte, longint hi_byte);
      longint first;
      longint last;
      first = lo_byte / FRAME_BYTES;
      last = (hi_byte + FRAME_BYTES - 1) / FRAME_BYTES;
      if (last > NUM_FRAMES) begin
         last = NUM_FRAMES;
      end
      for (longint p = first; p < last; p++) begin
         frame_free[p] = 1'b0;
         frame_count[p] = -8'sd1;
      end
   endfunction

   function automatic rsp_type apply_page_op(req_type item);
      rsp_type reply;
      int page;
      int hit;
      longint base;
      reply.page_address = '0;
      reply.status = STATUS_OK;
      page = int'(item.address / FRAME_BYTES);
      case (item.mode)
         MODE_ALLOC: begin
            reply.status = STATUS_NO_FREE;
            hit = -1;
            for (int p = 0; p < NUM_FRAMES && hit < 0; p++) begin
               if (frame_free[p]) begin
                  hit = p;
               end
            end
            if (hit >= 0) begin
               frame_free[hit] = 1'b0;
               frame_count[hit] = 8'sd1;
               reply.page_address = ADDR_W'(longint'(hit) * FRAME_BYTES);
               reply.status = STATUS_OK;
            end
         end
         MODE_FREE: begin
            if (page >= NUM_FRAMES) begin
               reply.status = STATUS_RANGE;
            end else if (!frame_free[page] && frame_count[page] > 8'sd0) begin
               frame_count[page] = frame_count[page] - 8'sd1;
               if (frame_count[page] == 8'sd0) begin
                  frame_free[page] = 1'b1;
               end
            end
         end
         MODE_REF: begin
            if (page >= NUM_FRAMES) begin
               reply.status = STATUS_RANGE;
            end else begin
               frame_free[page] = 1'b0;
               if (frame_count[page] < COUNT_MAX) begin
                  frame_count[page] = frame_count[page] + 8'sd1;
               end
            end
         end
         default: begin
            for (int p = 0; p < NUM_FRAMES; p++) begin
               base = longint'(p) * FRAME_BYTES;
               frame_free[p] = base >= longint'(region_reg[CSR_USABLE_START]) &&
                               base < longint'(region_reg[CSR_USABLE_END]);
               frame_count[p] = 8'sd0;
            end
            reserve_frames(longint'(region_reg[CSR_KERNEL_START]),
                           longint'(region_reg[CSR_KERNEL_END]));
            reserve_frames(longint'(HOLE_START), longint'(HOLE_END));
         end
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_replies.push_back(apply_page_op(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (send_calm > 0) begin
               send_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               send_calm = $urandom_range(10, 40);
            end
            if (request_backlog.size() != 0 &&
                (send_calm > 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
               req_valid <= 1'b1;
               req_data <= request_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: reply with none expected: page_address %h status %0d",
                        $time, rsp_data.page_address, rsp_data.status);
            end else begin
               oldest_reply = predicted_replies.pop_front();
               if (rsp_data.page_address !== oldest_reply.page_address) begin
                  mismatch_count++;
                  $display("%0t: page_address expected %h actual %h", $time,
                           oldest_reply.page_address, rsp_data.page_address);
               end
               if (rsp_data.status !== oldest_reply.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           oldest_reply.status, rsp_data.status);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_calm > 0) begin
            recv_calm--;
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 49) == 0) begin
               recv_calm = $urandom_range(10, 40);
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic queue_item(mode_type mode, logic [ADDR_W-1:0] address);
      req_type item;
      item.mode = mode;
      item.address = address;
      request_backlog.push_back(item);
   endtask

   task automatic write_region(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      region_reg[idx] = value;
   endtask

   task automatic load_regions(longint us, longint ue, longint ks, longint ke);
      write_region(CSR_USABLE_START, CSR_W'(us));
      write_region(CSR_USABLE_END, CSR_W'(ue));
      write_region(CSR_KERNEL_START, CSR_W'(ks));
      write_region(CSR_KERNEL_END, CSR_W'(ke));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_replies();
      @(negedge clock);
      while (request_backlog.size() != 0 || predicted_replies.size() != 0 || req_valid) begin
         @(negedge clock);
      end
   endtask

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("page_frame_refcount_allocator_core verification failed");
      $finish;
   end

   initial begin
      longint us;
      longint ue;
      longint ks;
      longint ke;
      int kind;
      int bp;
      int span;
      int lo_page;
      int hi_page;
      int pick;
      int page_sel;
      logic [ADDR_W-1:0] target;

      region_reg[CSR_USABLE_START] = 25'h0100000;
      region_reg[CSR_USABLE_END] = 25'h1000000;
      region_reg[CSR_KERNEL_START] = 25'h0100000;
      region_reg[CSR_KERNEL_END] = 25'h0200000;
      for (int p = 0; p < NUM_FRAMES; p++) begin
         frame_free[p] = 1'b0;
         frame_count[p] = 8'sd0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_item(MODE_ALLOC, 24'h000000);
      queue_item(MODE_FREE, 24'h000000);
      queue_item(MODE_REF, 24'h005000);
      queue_item(MODE_REF, 24'h005FFF);
      queue_item(MODE_FREE, 24'h005000);
      queue_item(MODE_FREE, 24'h005123);
      queue_item(MODE_ALLOC, 24'h000000);
      queue_item(MODE_FREE, 24'hFFFFFF);
      queue_item(MODE_REF, 24'hFFFFFF);
      queue_item(MODE_INIT, 24'h000000);
      queue_item(MODE_ALLOC, 24'h000000);
      queue_item(MODE_REF, 24'h0A0000);
      queue_item(MODE_FREE, 24'h0A0000);
      queue_item(MODE_REF, 24'h0A0FFF);
      queue_item(MODE_FREE, 24'h0A0000);
      queue_item(MODE_ALLOC, 24'h000000);
      drain_replies();

      load_regions(24'hFFF000, TOP_BYTE, 0, 0);
      queue_item(MODE_INIT, 24'hFFFFFF);
      queue_item(MODE_ALLOC, 24'h000000);
      queue_item(MODE_ALLOC, 24'h000000);
      queue_item(MODE_FREE, 24'hFFF000);
      queue_item(MODE_ALLOC, 24'h000000);
      drain_replies();

      load_regions(0, TOP_BYTE, TOP_BYTE, TOP_BYTE);
      queue_item(MODE_INIT, 24'h000000);
      queue_item(MODE_ALLOC, 24'h000000);
      drain_replies();

      load_regions(0, TOP_BYTE, 0, TOP_BYTE);
      queue_item(MODE_INIT, 24'h000000);
      queue_item(MODE_ALLOC, 24'h000000);
      drain_replies();

      for (int phase = 0; phase < 16; phase++) begin
         if (phase < 6) begin
            send_idle_pct = 34;
            recv_idle_pct = 74;
         end else if (phase < 12) begin
            send_idle_pct = 74;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         kind = $urandom_range(0, 3);
         case (kind)
            0: begin
               bp = $urandom_range(0, 4000);
               span = $urandom_range(1, 48);
               us = longint'(bp) * FRAME_BYTES;
               ue = longint'(bp + span) * FRAME_BYTES;
               ks = us + $urandom_range(0, span * FRAME_BYTES);
               ke = ks + $urandom_range(0, 6 * FRAME_BYTES);
            end
            1: begin
               us = $urandom_range(0, 24'hFF0000);
               ue = us + $urandom_range(0, 40 * FRAME_BYTES);
               ks = $urandom_range(0, 25'h1000000);
               ke = $urandom_range(0, 25'h1000000);
            end
            2: begin
               ue = $urandom_range(0, 24'hFF0000);
               us = ue + $urandom_range(1, 20 * FRAME_BYTES);
               ks = $urandom_range(0, 25'h1000000);
               ke = ks;
            end
            default: begin
               us = $urandom_range(0, 25'h0100000);
               ue = TOP_BYTE;
               ks = $urandom_range(0, 25'h0300000);
               ke = ks + $urandom_range(0, 25'h0080000);
            end
         endcase
         if (us > TOP_BYTE) begin
            us = TOP_BYTE;
         end
         if (ue > TOP_BYTE) begin
            ue = TOP_BYTE;
         end
         if (ke > TOP_BYTE) begin
            ke = TOP_BYTE;
         end
         load_regions(us, ue, ks, ke);

         lo_page = int'(us / FRAME_BYTES);
         hi_page = int'((ue + FRAME_BYTES - 1) / FRAME_BYTES);
         if (hi_page <= lo_page) begin
            hi_page = lo_page + 4;
         end
         if (hi_page > NUM_FRAMES - 1) begin
            hi_page = NUM_FRAMES - 1;
         end
         if (lo_page > hi_page) begin
            lo_page = hi_page;
         end

         queue_item(MODE_INIT, ADDR_W'($urandom()));
         for (int op = 0; op < 19; op++) begin
            pick = $urandom_range(0, 99);
            page_sel = $urandom_range(lo_page, hi_page);
            target = ADDR_W'(page_sel * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
            if ($urandom_range(0, 7) == 0) begin
               target = ADDR_W'($urandom());
            end
            if (pick < 35) begin
               queue_item(MODE_ALLOC, ADDR_W'($urandom()));
            end else if (pick < 60) begin
               queue_item(MODE_REF, target);
            end else if (pick < 88) begin
               queue_item(MODE_FREE, target);
            end else if (pick < 92) begin
               queue_item(MODE_INIT, target);
            end else begin
               queue_item(mode_type'($urandom_range(0, 3)), ADDR_W'($urandom()));
            end
         end
         if (phase == 4) begin
            target = ADDR_W'(lo_page * FRAME_BYTES);
            for (int op = 0; op < 130; op++) begin
               queue_item(MODE_REF, target);
            end
            for (int op = 0; op < 3; op++) begin
               queue_item(MODE_FREE, target);
            end
         end
         if (phase == 12) begin
            @(negedge clock);
            hold_requests++;
         end
         drain_replies();
      end

      repeat (20) @(posedge clock);
      if (predicted_replies.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
      end
      if (mismatch_count == 0) begin
         $display("page_frame_refcount_allocator_core verification clean");
      end else begin
         $display("page_frame_refcount_allocator_core verification failed");
      end
      $finish;
   end

endmodule
